// ===== src/cfsp_pkg.sv =====
// Package for the CRC framed setpoint packer: frame constants and CRC helpers.
package cfsp_pkg;

  localparam int unsigned FrameLen = 21;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CrcSteps = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [IdxW-1:0] IdxCrcLo  = 5'd5;
  localparam logic [IdxW-1:0] IdxCrcHi  = 5'd6;
  localparam logic [IdxW-1:0] IdxAddr0  = 5'd14;
  localparam logic [IdxW-1:0] IdxValue0 = 5'd17;
  localparam logic [IdxW-1:0] IdxLast   = 5'd20;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] AddrKw0 = 8'h8D;
  localparam logic [7:0] AddrPf0 = 8'h87;

  // One byte of CRC-16 XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC over the nine fixed bytes ahead of the value: 00 19 00 01 20 04 addr 02 31.
  function automatic logic [15:0] crc_seed(logic pf);
    logic [15:0] c;
    c = 16'h0000;
    c = crc_byte(c, 8'h00);
    c = crc_byte(c, 8'h19);
    c = crc_byte(c, 8'h00);
    c = crc_byte(c, 8'h01);
    c = crc_byte(c, 8'h20);
    c = crc_byte(c, 8'h04);
    c = crc_byte(c, pf ? AddrPf0 : AddrKw0);
    c = crc_byte(c, 8'h02);
    c = crc_byte(c, 8'h31);
    return c;
  endfunction

  // Fixed frame bytes by position; zero where the byte is computed.
  function automatic logic [7:0] frame_const(logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h48;
      5'd1:    b = 8'h41;
      5'd2:    b = 8'h50;
      5'd3:    b = 8'h2B;
      5'd4:    b = 8'h54;
      5'd7:    b = 8'h0C;
      5'd8:    b = 8'h00;
      5'd9:    b = 8'h19;
      5'd10:   b = 8'h00;
      5'd11:   b = 8'h01;
      5'd12:   b = 8'h20;
      5'd13:   b = 8'h04;
      5'd15:   b = 8'h02;
      5'd16:   b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/crc_framed_setpoint_packer.sv =====
// Top level: packs one setpoint command into a 21-byte CRC framed message.
// The first frame byte passes through the sequencer and then the output register.
// One frame byte per cycle while the receiver does not stall; the next
//   input beat is taken in the cycle the last byte of the frame is loaded.
// The CRC runs one value byte per cycle during the header bytes, done by byte 5.
// Reset (rst_ni low, async) empties the sequencer and the output register.
module crc_framed_setpoint_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_o
);

  // CRC over the fixed prefix, per address, folded at elaboration.
  localparam logic [15:0] SeedKw = cfsp_pkg::crc_seed(1'b0);
  localparam logic [15:0] SeedPf = cfsp_pkg::crc_seed(1'b1);

  // Sequencer state
  logic                      busy_q, busy_d;
  logic [cfsp_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      cmd_q, cmd_d;
  logic [31:0]               val_q, val_d;

  // Running CRC, one value byte per cycle
  logic [15:0]               crc_q, crc_d;
  logic [cfsp_pkg::CntW-1:0] cnt_q, cnt_d;

  // Output register
  logic                      oval_q, oval_d;
  logic [7:0]                obyte_q, obyte_d;
  logic                      olast_q, olast_d;

  logic                      adv;
  logic                      in_beat;
  logic [7:0]                cur_byte;
  logic [cfsp_pkg::IdxW-1:0] voff;

  // Load the next frame byte when the output slot is free or draining.
  assign adv     = busy_q && (!oval_q || out_ready_i);
  // Take a new beat when idle or while the last byte is being loaded.
  assign in_ready_o = !busy_q || (adv && (idx_q == cfsp_pkg::IdxLast));
  assign in_beat = in_valid_i && in_ready_o;

  assign voff = idx_q - cfsp_pkg::IdxValue0;

  // Byte mux for the current position
  always_comb begin
    if (idx_q == cfsp_pkg::IdxCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (idx_q == cfsp_pkg::IdxCrcHi) begin
      cur_byte = crc_q[15:8];
    end else if (idx_q == cfsp_pkg::IdxAddr0) begin
      cur_byte = cmd_q ? cfsp_pkg::AddrPf0 : cfsp_pkg::AddrKw0;
    end else if (idx_q >= cfsp_pkg::IdxValue0) begin
      cur_byte = val_q[8*voff[1:0] +: 8];
    end else begin
      cur_byte = cfsp_pkg::frame_const(idx_q);
    end
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    val_d   = val_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q;
    obyte_d = obyte_q;
    olast_d = olast_q;

    // Output slot
    if (adv) begin
      oval_d  = 1'b1;
      obyte_d = cur_byte;
      olast_d = (idx_q == cfsp_pkg::IdxLast);
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end

    // CRC over value bytes, LSB first
    if (busy_q && (cnt_q != cfsp_pkg::CntW'(cfsp_pkg::CrcSteps))) begin
      crc_d = cfsp_pkg::crc_byte(crc_q, val_q[8*cnt_q[1:0] +: 8]);
      cnt_d = cnt_q + 1'b1;
    end

    // Sequencer
    if (adv) begin
      if (idx_q == cfsp_pkg::IdxLast) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (in_beat) begin
      busy_d = 1'b1;
      idx_d  = '0;
      cmd_d  = cmd_i;
      val_d  = value_bits_i;
      crc_d  = cmd_i ? SeedPf : SeedKw;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      oval_q <= oval_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    val_q   <= val_d;
    crc_q   <= crc_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = oval_q;
  assign frame_byte_o = obyte_q;
  assign last_o       = olast_q;

`ifndef ASSERT_OFF
  // CRC must be complete before its bytes are loaded.
  a_crc_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (idx_q >= cfsp_pkg::IdxCrcLo))
      |-> (cnt_q == cfsp_pkg::CntW'(cfsp_pkg::CrcSteps)))
    else $error("CRC not finished when needed");

  // Position never runs past the final byte.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= cfsp_pkg::IdxLast))
    else $error("frame position out of range");

  // An accepted beat restarts the frame at the header.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (busy_q && (idx_q == '0)))
    else $error("frame did not restart");

  // Loading the final position is followed by a valid byte with the last flag.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (idx_q == cfsp_pkg::IdxLast)) |=> (out_valid_o && last_o))
    else $error("last flag missing");
`endif

endmodule

// ===== bench/crc_framed_setpoint_packer_test.sv =====
// Testbench for crc_framed_setpoint_packer: setpoint beats in, predicted 21-byte frames checked.
`timescale 1ns / 100ps

module crc_framed_setpoint_packer_test;

  localparam int FrameBytes  = 21;
  localparam int MaxReports  = 10;
  // Longest run of cycles with no beat moving before the run is declared hung.
  // A correct run keeps beats moving; even at 69% receiver stall a quiet
  // stretch that long is out of reach.
  localparam int StallLimit  = 2000;
  // Settle time after the last frame byte.
  localparam int DrainCycles = 8;
  localparam int BeatsPerRun = 110;

  // Setpoint selector codes.
  localparam logic CmdKw = 1'b0;
  localparam logic CmdPf = 1'b1;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        cmd_i        = 1'b0;
  logic [31:0] value_bits_i = '0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  frame_byte_o;
  logic        last_o;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Frame bytes still owed by the block, oldest first.
  frame_beat_t expected_beats[$];

  int unsigned mismatch_count     = 0;
  int unsigned quiet_cycles       = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  crc_framed_setpoint_packer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_bits_i (value_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // CRC-16 XMODEM, one message bit at a time: feedback is the CRC MSB
  // xor the incoming bit, MSB of the byte first.
  function automatic logic [15:0] xmodem_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  // Build the frame for one setpoint and queue its 21 bytes.
  task automatic queue_setpoint_frame(input logic cmd, input logic [31:0] value);
    logic [7:0]  frame [FrameBytes];
    logic [15:0] crc;
    frame[0]  = 8'h48;
    frame[1]  = 8'h41;
    frame[2]  = 8'h50;
    frame[3]  = 8'h2B;
    frame[4]  = 8'h54;
    frame[7]  = 8'h0C;
    frame[8]  = 8'h00;
    frame[9]  = 8'h19;
    frame[10] = 8'h00;
    frame[11] = 8'h01;
    frame[12] = 8'h20;
    frame[13] = 8'h04;
    frame[14] = (cmd == CmdPf) ? 8'h87 : 8'h8D;
    frame[15] = 8'h02;
    frame[16] = 8'h31;
    // value goes out least significant byte first
    for (int i = 0; i < 4; i++) begin
      frame[17 + i] = value[8*i +: 8];
    end
    // CRC covers the trailing 13 bytes, from 00 19 ... through the value
    crc = 16'h0000;
    for (int i = 8; i < FrameBytes; i++) begin
      crc = xmodem_update(crc, frame[i]);
    end
    frame[5] = crc[7:0];
    frame[6] = crc[15:8];
    for (int i = 0; i < FrameBytes; i++) begin
      expected_beats.push_back(frame_beat_t'{data: frame[i], last: (i == FrameBytes - 1)});
    end
  endtask

  // Offer one setpoint beat, with random sender gaps ahead of it. Valid is
  // left high on return so a following beat can go back to back.
  task automatic send_setpoint(input logic cmd, input logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    value_bits_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    queue_setpoint_frame(cmd, value);
  endtask

  // Random float patterns, skewed toward the all-ones and all-zero exponents
  // so NaN, infinity, zero and denormal shapes turn up often.
  function automatic logic [31:0] random_setpoint();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0:       v[30:23] = 8'hFF;
      1:       v[30:23] = 8'h00;
      2:       v[22:0]  = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random_setpoints(input int count);
    for (int n = 0; n < count; n++) begin
      send_setpoint(logic'($urandom_range(1)), random_setpoint());
    end
  endtask

  // Both addresses against the corner bit patterns of a float, no idling.
  task automatic test_special_values();
    logic [31:0] patterns [11];
    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7F80_0000,
                 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001,
                 32'h807F_FFFF, 32'h3F80_0000, 32'hA5A5_5A5A};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    foreach (patterns[i]) begin
      send_setpoint(CmdKw, patterns[i]);
      send_setpoint(CmdPf, patterns[i]);
    end
  endtask

  task automatic test_back_to_back();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_setpoints(BeatsPerRun);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 69;
    receiver_stall_pct = 0;
    run_random_setpoints(BeatsPerRun);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 69;
    run_random_setpoints(BeatsPerRun);
  endtask

  task automatic test_mixed_idling();
    sender_idle_pct    = 18;
    receiver_stall_pct = 18;
    run_random_setpoints(BeatsPerRun);
  endtask

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Frame byte checker: every accepted output beat against the oldest
  // expectation, both fields.
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        if (mismatch_count < MaxReports) begin
          $display("unexpected frame beat: byte %h last %b", frame_byte_o, last_o);
        end
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (frame_byte_o !== want.data || last_o !== want.last) begin
          if (mismatch_count < MaxReports) begin
            $display("frame beat mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, frame_byte_o, last_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side stops the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat moved in %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_special_values();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    // last beat taken in this step; drop valid and drain the frames
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
